// ===== rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative LRU cache lookup core.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int MaxSets   = 128;
  localparam int MaxWays   = 8;
  localparam int SetW      = $clog2(MaxSets);
  localparam int WayW      = $clog2(MaxWays);
  localparam int AddrW     = 64;
  localparam int StampW    = 32;
  localparam int LatW      = 16;
  localparam int CntW      = 32;
  localparam int TotW      = 48;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_BITS = 3'd0,
    CFG_INDEX_BITS  = 3'd1,
    CFG_WAYS        = 3'd2,
    CFG_HIT_LAT     = 3'd3,
    CFG_MEM_LAT     = 3'd4
  } cfg_idx_t;

  // One decoded access travelling from front to back
  typedef struct packed {
    logic              is_write;
    logic [SetW-1:0]   set;
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] stamp;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [WayW-1:0]   way;
    logic              write_back;
    logic [LatW-1:0]   access_latency;
    logic [CntW-1:0]   hit_count;
    logic [CntW-1:0]   reference_count;
    logic [TotW-1:0]   latency_total;
  } resp_t;

endpackage

// ===== rtl/salc_if.sv =====
// ----------------------------------------------------------------------------
// salc_if
// Channel interfaces: access input, result output and configuration writes.
// ----------------------------------------------------------------------------
interface salc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [salc_pkg::AddrW-1:0]      address;
  logic [salc_pkg::StampW-1:0]     stamp;
  modport source (output valid, op, address, stamp, input ready);
  modport sink   (input valid, op, address, stamp, output ready);
endinterface

interface salc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [salc_pkg::WayW-1:0]       way;
  logic                            write_back;
  logic [salc_pkg::LatW-1:0]       access_latency;
  logic [salc_pkg::CntW-1:0]       hit_count;
  logic [salc_pkg::CntW-1:0]       reference_count;
  logic [salc_pkg::TotW-1:0]       latency_total;
  modport source (output valid, hit, way, write_back, access_latency, hit_count,
                  reference_count, latency_total, input ready);
  modport sink   (input valid, hit, way, write_back, access_latency, hit_count,
                  reference_count, latency_total, output ready);
endinterface

interface salc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [salc_pkg::CfgIdxW-1:0]      index;
  logic [salc_pkg::CfgDataW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/salc_front.sv =====
// ----------------------------------------------------------------------------
// salc_front
// Accepts accesses, splits the address into set and tag, and queues them.
// ----------------------------------------------------------------------------
module salc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  salc_in_if.sink              in_ch,
  input  logic [3:0]           offset_bits,
  input  logic [2:0]           index_bits,
  output logic                 q_valid,
  output salc_pkg::req_t       q_req,
  input  logic                 q_pop
);

  localparam int PtrW = $clog2(salc_pkg::QueueDepth);

  salc_pkg::req_t       mem_r [salc_pkg::QueueDepth];
  logic [PtrW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]        cnt_r;
  logic                 push;
  logic [salc_pkg::AddrW-1:0] shifted;
  logic [salc_pkg::AddrW-1:0] set_mask;
  logic [4:0]           tag_sh;
  salc_pkg::req_t       dec;

  // Decode set and tag
  always_comb begin
    shifted  = in_ch.address >> offset_bits;
    set_mask = ({{(salc_pkg::AddrW-1){1'b0}}, 1'b1} << index_bits) - 64'd1;
    tag_sh   = {1'b0, offset_bits} + {2'b00, index_bits};
    dec.is_write = ~in_ch.op;
    dec.set      = salc_pkg::SetW'(shifted & set_mask);
    dec.tag      = in_ch.address >> tag_sh;
    dec.stamp    = in_ch.stamp;
  end

  assign in_ch.ready = (cnt_r != (PtrW+1)'(salc_pkg::QueueDepth));
  assign push        = in_ch.valid & in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_req       = mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)  wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(q_pop && cnt_r == '0)) else $error("pop from empty queue");
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(salc_pkg::QueueDepth)) else $error("queue overflow");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop without entry");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");

endmodule

// ===== rtl/salc_back.sv =====
// ----------------------------------------------------------------------------
// salc_back
// Reads a set, matches tags, picks a victim, updates lines and totals.
// ----------------------------------------------------------------------------
module salc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  salc_pkg::req_t       q_req,
  output logic                 q_pop,
  input  logic [3:0]           ways_in_use,
  input  logic [15:0]          hit_latency,
  input  logic [15:0]          memory_latency,
  output logic                 busy,
  salc_out_if.source           out_ch
);

  localparam int NW = salc_pkg::MaxWays;
  localparam int WW = salc_pkg::WayW;
  localparam int LineW = salc_pkg::SetW + WW;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_OUT} state_t;

  state_t state_r;

  // Valid and dirty marks per set, cleared by a pass after reset; tags and
  // stamps in memories per way
  logic [NW-1:0] valid_r [salc_pkg::MaxSets];
  logic [NW-1:0] dirty_r [salc_pkg::MaxSets];
  logic [salc_pkg::AddrW-1:0]  tag_mem   [NW][salc_pkg::MaxSets];
  logic [salc_pkg::StampW-1:0] stamp_mem [NW][salc_pkg::MaxSets];

  logic [salc_pkg::AddrW-1:0]  rd_tag_r   [NW];
  logic [salc_pkg::StampW-1:0] rd_stamp_r [NW];
  logic [NW-1:0]               rd_valid_r, rd_dirty_r;
  salc_pkg::req_t              req_r;

  logic [salc_pkg::CntW-1:0]   hits_r, refs_r;
  logic [salc_pkg::TotW-1:0]   lat_tot_r;
  salc_pkg::resp_t             resp_r;

  logic                        clr_busy_r;
  logic [salc_pkg::SetW-1:0]   clr_idx_r;

  logic [WW:0]                 nways;
  logic [NW-1:0]               act, match;
  logic                        hit;
  logic [WW-1:0]               hit_way, free_way, lru_way, way_sel;
  logic                        any_free, wb;
  logic [salc_pkg::StampW-1:0] oldest;
  logic [salc_pkg::LatW-1:0]   lat;
  logic [NW-1:0]               way_oh, valid_nxt, dirty_nxt;
  logic                        start;

  // Clamp the associativity
  always_comb begin
    if (ways_in_use == 4'd0)         nways = (WW+1)'(1);
    else if (ways_in_use > 4'(NW))   nways = (WW+1)'(NW);
    else                             nways = (WW+1)'(ways_in_use);
    for (int i = 0; i < NW; i++) act[i] = (i < int'(nways));
  end

  // Match, free search and LRU search over the read set
  always_comb begin
    hit = 1'b0; hit_way = '0; any_free = 1'b0; free_way = '0;
    lru_way = '0; oldest = rd_stamp_r[0];
    for (int i = 0; i < NW; i++) begin
      match[i] = act[i] & rd_valid_r[i] & (rd_tag_r[i] == req_r.tag);
    end
    for (int i = NW-1; i >= 0; i--) begin
      if (match[i]) begin hit = 1'b1; hit_way = WW'(i); end
      if (act[i] && !rd_valid_r[i]) begin any_free = 1'b1; free_way = WW'(i); end
    end
    for (int i = 1; i < NW; i++) begin
      if (act[i] && rd_stamp_r[i] < oldest) begin
        oldest = rd_stamp_r[i]; lru_way = WW'(i);
      end
    end
    way_sel   = hit ? hit_way : (any_free ? free_way : lru_way);
    wb        = !hit && !any_free && rd_dirty_r[lru_way];
    lat       = hit ? hit_latency : memory_latency;
    way_oh    = NW'(1) << way_sel;
    valid_nxt = rd_valid_r | way_oh;
    dirty_nxt = hit ? (rd_dirty_r | (req_r.is_write ? way_oh : '0))
                    : (rd_dirty_r & ~way_oh);
  end

  assign start  = (state_r == S_IDLE) && q_valid && !clr_busy_r;
  assign q_pop  = start;
  assign busy   = (state_r != S_IDLE) || q_valid;

  // Clear one set of valid and dirty marks per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == salc_pkg::SetW'(salc_pkg::MaxSets-1)) clr_busy_r <= 1'b0;
    end
  end

  // Read the set into registers in the cycle before the compare
  always_ff @(posedge clk) begin
    if (start) begin
      req_r      <= q_req;
      rd_valid_r <= valid_r[q_req.set];
      rd_dirty_r <= dirty_r[q_req.set];
      for (int i = 0; i < NW; i++) begin
        rd_tag_r[i]   <= tag_mem[i][q_req.set];
        rd_stamp_r[i] <= stamp_mem[i][q_req.set];
      end
    end
  end

  // Write the valid and dirty marks of the touched set
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      valid_r[clr_idx_r] <= '0;
      dirty_r[clr_idx_r] <= '0;
    end else if (state_r == S_CMP) begin
      valid_r[req_r.set] <= valid_nxt;
      dirty_r[req_r.set] <= dirty_nxt;
    end
  end

  // Write tag and stamp of the touched way
  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      for (int i = 0; i < NW; i++) begin
        if (way_sel == WW'(i)) begin
          stamp_mem[i][req_r.set] <= req_r.stamp;
          if (!hit) tag_mem[i][req_r.set] <= req_r.tag;
        end
      end
    end
  end

  // Sequence: read, compare and update, present result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      hits_r    <= '0;
      refs_r    <= '0;
      lat_tot_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_CMP;
        end
        S_CMP: begin
          hits_r    <= hits_r + salc_pkg::CntW'(hit);
          refs_r    <= refs_r + 1'b1;
          lat_tot_r <= lat_tot_r + salc_pkg::TotW'(lat);
          resp_r.hit             <= hit;
          resp_r.way             <= way_sel;
          resp_r.write_back      <= wb;
          resp_r.access_latency  <= lat;
          resp_r.hit_count       <= hits_r + salc_pkg::CntW'(hit);
          resp_r.reference_count <= refs_r + 1'b1;
          resp_r.latency_total   <= lat_tot_r + salc_pkg::TotW'(lat);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = (state_r == S_OUT);
  assign out_ch.hit             = resp_r.hit;
  assign out_ch.way             = resp_r.way;
  assign out_ch.write_back      = resp_r.write_back;
  assign out_ch.access_latency  = resp_r.access_latency;
  assign out_ch.hit_count       = resp_r.hit_count;
  assign out_ch.reference_count = resp_r.reference_count;
  assign out_ch.latency_total   = resp_r.latency_total;

  a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && hit) |-> !wb) else $error("write-back on hit");
  a_refs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |=> refs_r == $past(refs_r) + 1'b1) else $error("refs slip");
  a_way: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> {1'b0, way_sel} < nways) else $error("way out of range");
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !start) else $error("access started during clear");

endmodule

// ===== rtl/set_assoc_lru_cache_lookup_core.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_core
// Set-associative write-back cache lookup with LRU replacement.
// ----------------------------------------------------------------------------
// Each access passes through the lookup engine as set read, compare and update,
// and result handoff, then waits for the result to be taken; the set read and
// the line update share the per-way tag and stamp memories, and the engine
// starts no new access until its last result is taken. A two-word queue ahead
// of the engine lets accesses be taken while a result waits. After reset the
// engine clears the valid and dirty marks one set per cycle and starts no
// access before that pass ends; the queue still takes two words meanwhile.
// Configuration is accepted at any time but must be written only idle.
module set_assoc_lru_cache_lookup_core (
  input  logic         clk,
  input  logic         rst_n,
  salc_in_if.sink      in_ch,
  salc_out_if.source   out_ch,
  salc_cfg_if.sink     cfg_ch
);

  logic [3:0]  offset_bits_r;
  logic [2:0]  index_bits_r;
  logic [3:0]  ways_r;
  logic [15:0] hit_lat_r, mem_lat_r;
  logic        q_valid, q_pop, busy;
  salc_pkg::req_t q_req;

  assign cfg_ch.ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= 4'd6;
      index_bits_r  <= 3'd6;
      ways_r        <= 4'd4;
      hit_lat_r     <= 16'd1;
      mem_lat_r     <= 16'd100;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        salc_pkg::CFG_OFFSET_BITS: offset_bits_r <= cfg_ch.data[3:0];
        salc_pkg::CFG_INDEX_BITS:  index_bits_r  <= cfg_ch.data[2:0];
        salc_pkg::CFG_WAYS:        ways_r        <= cfg_ch.data[3:0];
        salc_pkg::CFG_HIT_LAT:     hit_lat_r     <= cfg_ch.data;
        salc_pkg::CFG_MEM_LAT:     mem_lat_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  salc_front u_front (
    .clk, .rst_n, .in_ch,
    .offset_bits(offset_bits_r), .index_bits(index_bits_r),
    .q_valid, .q_req, .q_pop
  );

  salc_back u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop,
    .ways_in_use(ways_r), .hit_latency(hit_lat_r), .memory_latency(mem_lat_r),
    .busy, .out_ch
  );

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> busy) else $error("result while idle");
  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.ready) else $error("config stalled");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_ch.valid) else $error("pop while result pending");

endmodule

// ===== tb/sv/set_assoc_lru_cache_lookup_core_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_core_tb
// Drives cache accesses through the lookup core and checks every result word
// against a local model of the tags, stamps, dirty marks and running totals.
// Both sides idle at random. Configuration changes only while the core is idle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_core_tb;
  import salc_pkg::*;

  localparam int                 Lines     = MaxSets * MaxWays;
  localparam int                 IdleLimit = 4000;
  localparam int                 DrainWait = 16;
  localparam logic               OpWrite   = 1'b0;
  localparam logic               OpRead    = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  logic clk;
  logic rst_n;

  salc_in_if  in_ch ();
  salc_out_if out_ch ();
  salc_cfg_if cfg_ch ();

  set_assoc_lru_cache_lookup_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Local copy of the cache state and settings
  logic [3:0]        offset_bits;
  logic [2:0]        index_bits;
  logic [3:0]        ways_in_use;
  logic [LatW-1:0]   hit_lat;
  logic [LatW-1:0]   mem_lat;
  logic              line_valid [Lines];
  logic              line_dirty [Lines];
  logic [AddrW-1:0]  line_tag   [Lines];
  logic [StampW-1:0] line_stamp [Lines];
  logic [CntW-1:0]   hits_seen;
  logic [CntW-1:0]   refs_seen;
  logic [TotW-1:0]   lat_sum;

  resp_t       expected_results [$];
  int          fault_count;
  int          stall_left;
  int          idle_cycles;
  bit          no_idle;
  logic [31:0] stamp_clock;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Work out the result of one access and update the local cache state
  function automatic resp_t cache_access(logic op, logic [AddrW-1:0] addr,
                                         logic [StampW-1:0] stamp);
    resp_t       r;
    logic [63:0] set_no;
    logic [63:0] tag;
    int          nways;
    int          base;
    int          l;
    bit          found;
    logic [StampW-1:0] oldest;
    set_no = (addr >> offset_bits) & ((64'd1 << index_bits) - 64'd1);
    tag    = addr >> (5'(offset_bits) + 5'(index_bits));
    nways  = (ways_in_use == 0) ? 1 : (ways_in_use > MaxWays) ? MaxWays : ways_in_use;
    base   = int'(set_no % MaxSets) * MaxWays;
    r      = '0;
    found  = 1'b0;
    for (int w = 0; w < nways; w++) begin
      if (!r.hit && line_valid[base+w] && line_tag[base+w] == tag) begin
        r.hit = 1'b1;
        r.way = WayW'(w);
      end
    end
    refs_seen++;
    if (r.hit) begin
      l = base + r.way;
      hits_seen++;
      r.access_latency = hit_lat;
      line_stamp[l] = stamp;
      if (op == OpWrite) line_dirty[l] = 1'b1;
    end else begin
      r.access_latency = mem_lat;
      for (int w = 0; w < nways; w++) begin
        if (!found && !line_valid[base+w]) begin
          r.way = WayW'(w);
          found = 1'b1;
        end
      end
      // Evict the oldest stamp, lowest way on ties
      if (!found) begin
        oldest = line_stamp[base];
        r.way  = '0;
        for (int w = 1; w < nways; w++) begin
          if (line_stamp[base+w] < oldest) begin
            oldest = line_stamp[base+w];
            r.way  = WayW'(w);
          end
        end
        r.write_back = line_dirty[base+r.way];
      end
      l = base + r.way;
      line_valid[l] = 1'b1;
      line_dirty[l] = 1'b0;
      line_tag[l]   = tag;
      line_stamp[l] = stamp;
    end
    lat_sum += TotW'(r.access_latency);
    r.hit_count       = hits_seen;
    r.reference_count = refs_seen;
    r.latency_total   = lat_sum;
    return r;
  endfunction

  // Send one access word, then record what it should return
  task automatic send_access(logic op, logic [AddrW-1:0] addr, logic [StampW-1:0] stamp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.address <= addr;
    in_ch.stamp   <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(cache_access(op, addr, stamp));
  endtask

  // Drop valid and wait until every result is back and the core is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Write one register word
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_OFFSET_BITS: offset_bits = data[3:0];
      CFG_INDEX_BITS:  index_bits  = data[2:0];
      CFG_WAYS:        ways_in_use = data[3:0];
      CFG_HIT_LAT:     hit_lat     = data;
      CFG_MEM_LAT:     mem_lat     = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load a full setting; junk in the unused upper data bits must be dropped
  task automatic configure(logic [3:0] ob, logic [2:0] ib, logic [3:0] ways,
                           logic [15:0] hl, logic [15:0] ml);
    write_reg(CFG_OFFSET_BITS, {12'($urandom), ob});
    write_reg(CFG_INDEX_BITS, {13'($urandom), ib});
    write_reg(CFG_WAYS, {12'($urandom), ways});
    write_reg(CFG_HIT_LAT, hl);
    write_reg(CFG_MEM_LAT, ml);
  endtask

  function automatic logic [AddrW-1:0] make_addr(logic [63:0] tag, logic [63:0] set_no,
                                                 logic [63:0] off);
    return (tag << (5'(offset_bits) + 5'(index_bits)))
         | ((set_no & ((64'd1 << index_bits) - 1)) << offset_bits)
         | (off & ((64'd1 << offset_bits) - 1));
  endfunction

  // Fill, hit, dirty eviction, stamp ties and field extremes at reset settings
  task automatic test_directed();
    no_idle = 1'b1;
    send_access(OpWrite, make_addr(0, 0, 0), 32'd5);
    send_access(OpRead,  make_addr(1, 0, 63), 32'd5);
    send_access(OpWrite, make_addr(2, 0, 1), 32'd5);
    send_access(OpRead,  make_addr(3, 0, 2), 32'd9);
    send_access(OpWrite, make_addr(1, 0, 3), 32'd10);
    send_access(OpRead,  make_addr(0, 0, 0), 32'd5);
    // Set full: ties at stamp 5 pick the lowest way, a clean one; the dirty way goes later
    send_access(OpRead,  make_addr(4, 0, 0), 32'd11);
    send_access(OpRead,  make_addr(5, 0, 0), 32'd12);
    send_access(OpWrite, make_addr(6, 0, 0), 32'd13);
    send_access(OpRead,  make_addr(7, 0, 0), 32'd14);
    no_idle = 1'b0;
    send_access(OpWrite, {AddrW{1'b1}}, {StampW{1'b1}});
    send_access(OpRead,  {AddrW{1'b1}}, 32'd0);
    send_access(OpWrite, '0, {StampW{1'b1}});
    send_access(OpRead,  64'h5555_5555_5555_5555, 32'h5555_5555);
    send_access(OpWrite, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_access(OpRead,  64'hAAAA_AAAA_AAAA_AAAA, 32'h0000_0001);
    send_access(OpRead,  64'h8000_0000_0000_0000, 32'h8000_0000);
    drain();
  endtask

  // Random accesses clustered on a few sets and tags so hits and evictions recur
  task automatic run_phase(int count);
    logic [63:0] tag_pool [8];
    logic [63:0] set_pool [3];
    logic [63:0] addr;
    logic [31:0] stamp;
    for (int i = 0; i < 8; i++)
      tag_pool[i] = (i < 5) ? 64'(i) : {$urandom, $urandom};
    for (int i = 0; i < 3; i++) set_pool[i] = 64'($urandom);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85)
        addr = make_addr(tag_pool[$urandom_range(0, 7)], set_pool[$urandom_range(0, 2)],
                         {$urandom, $urandom});
      else
        addr = {$urandom, $urandom};
      stamp_clock += $urandom_range(0, 3);
      stamp = ($urandom_range(0, 19) == 0) ? $urandom : stamp_clock;
      send_access(1'($urandom), addr, stamp);
    end
    drain();
  endtask

  // Walk through several settings, the extremes among them
  task automatic test_settings();
    run_phase(100);
    configure(4'd0, 3'd0, 4'd1, 16'd0, 16'hFFFF);
    run_phase(80);
    configure(4'd15, 3'd7, 4'd15, 16'hFFFF, 16'd0);
    run_phase(80);
    configure(4'd13, 3'd2, 4'd0, 16'd3, 16'd250);
    run_phase(60);
    configure(4'd4, 3'd1, 4'd8, 16'd2, 16'd40);
    run_phase(80);
    // Shrink then grow the ways; stored lines stay
    write_reg(CFG_WAYS, 16'd2);
    run_phase(40);
    write_reg(CFG_WAYS, 16'd9);
    write_reg(CFG_OFFSET_BITS, 16'd12);
    run_phase(60);
    // Spare indexes must change nothing
    write_reg(CfgSpareA, 16'hFFFF);
    write_reg(CfgSpareB, 16'h0000);
    run_phase(40);
    configure(4'($urandom_range(0, 15)), 3'($urandom), 4'($urandom_range(0, 15)),
              16'($urandom), 16'($urandom));
    run_phase(60);
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    resp_t exp_r;
    int    n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("result word with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.hit !== exp_r.hit || out_ch.way !== exp_r.way
              || out_ch.write_back !== exp_r.write_back
              || out_ch.access_latency !== exp_r.access_latency
              || out_ch.hit_count !== exp_r.hit_count
              || out_ch.reference_count !== exp_r.reference_count
              || out_ch.latency_total !== exp_r.latency_total) begin
            fault_count++;
            if (fault_count <= 10) begin
              $write("exp hit=%0d way=%0d wb=%0d lat=%0d hits=%0d refs=%0d tot=%0d | ",
                     exp_r.hit, exp_r.way, exp_r.write_back, exp_r.access_latency,
                     exp_r.hit_count, exp_r.reference_count, exp_r.latency_total);
              $display("got hit=%0d way=%0d wb=%0d lat=%0d hits=%0d refs=%0d tot=%0d",
                       out_ch.hit, out_ch.way, out_ch.write_back, out_ch.access_latency,
                       out_ch.hit_count, out_ch.reference_count, out_ch.latency_total);
            end
          end
        end
        n = no_idle ? 0 : $urandom_range(0, 11);
        stall_left   <= n;
        out_ch.ready <= (n == 0);
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= (stall_left == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("set_assoc_lru_cache_lookup_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = 1'b0;
    in_ch.address = '0;
    in_ch.stamp   = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    fault_count   = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    stamp_clock   = 32'd100;
    offset_bits   = 4'd6;
    index_bits    = 3'd6;
    ways_in_use   = 4'd4;
    hit_lat       = 16'd1;
    mem_lat       = 16'd100;
    hits_seen     = '0;
    refs_seen     = '0;
    lat_sum       = '0;
    for (int i = 0; i < Lines; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_tag[i]   = '0;
      line_stamp[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    if (fault_count == 0) begin
      $display("set_assoc_lru_cache_lookup_core: match");
    end else begin
      $display("set_assoc_lru_cache_lookup_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/salc_pkg.sv
rtl/salc_if.sv
rtl/salc_front.sv
rtl/salc_back.sv
rtl/set_assoc_lru_cache_lookup_core.sv
tb/sv/set_assoc_lru_cache_lookup_core_tb.sv
